// ===== design/utf16_to_utf8_converter_defines.svh =====
// Assertion shorthands shared by the converter.
`ifndef UTF16_TO_UTF8_CONVERTER_DEFINES_SVH
`define UTF16_TO_UTF8_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UFC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define UFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ufc_pkg.sv =====
package ufc_pkg;

    localparam logic [15:0] HIGH_SURR_MIN = 16'hd800;
    localparam logic [15:0] HIGH_SURR_MAX = 16'hdbff;
    localparam logic [15:0] LOW_SURR_MIN  = 16'hdc00;
    localparam logic [15:0] LOW_SURR_MAX  = 16'hdfff;
    localparam logic [20:0] SUPP_BASE     = 21'h010000;
    localparam logic [20:0] REPL_CP       = 21'h00fffd;
    localparam logic [15:0] CAPACITY_RST  = 16'd256;

    localparam logic [7:0] LEAD4 = 8'hf0;
    localparam logic [7:0] LEAD3 = 8'he0;
    localparam logic [7:0] LEAD2 = 8'hc0;
    localparam logic [7:0] CONT  = 8'h80;
    localparam logic [7:0] CONT_MASK = 8'h3f;

    typedef logic [3:0][7:0] seq_bytes_t;

    typedef struct packed {
        seq_bytes_t bytes;
        logic [2:0] n;
    } enc_t;

    // One accepted unit's worth of output: up to two code points and a terminator.
    typedef struct packed {
        seq_bytes_t a_bytes;
        logic [2:0] a_n;
        seq_bytes_t b_bytes;
        logic [2:0] b_n;
        logic       term;
        logic [15:0] total_len;
    } job_t;

    function automatic enc_t encode_cp(input logic [20:0] cp);
        enc_t r;
        r.bytes = '0;
        if (cp <= 21'h00007f) begin
            r.bytes[0] = cp[7:0];
            r.n = 3'd1;
        end
        else if (cp <= 21'h0007ff) begin
            r.bytes[0] = LEAD2 | {3'b000, cp[10:6]};
            r.bytes[1] = CONT | ({2'b00, cp[5:0]} & CONT_MASK);
            r.n = 3'd2;
        end
        else if (cp <= 21'h00ffff) begin
            r.bytes[0] = LEAD3 | {4'b0000, cp[15:12]};
            r.bytes[1] = CONT | ({2'b00, cp[11:6]} & CONT_MASK);
            r.bytes[2] = CONT | ({2'b00, cp[5:0]} & CONT_MASK);
            r.n = 3'd3;
        end
        else begin
            r.bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
            r.bytes[1] = CONT | ({2'b00, cp[17:12]} & CONT_MASK);
            r.bytes[2] = CONT | ({2'b00, cp[11:6]} & CONT_MASK);
            r.bytes[3] = CONT | ({2'b00, cp[5:0]} & CONT_MASK);
            r.n = 3'd4;
        end
        return r;
    endfunction

endpackage

// ===== design/ufc_in_if.sv =====
interface ufc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_unit;

    modport source (output valid, output code_unit, output last_unit, input ready);
    modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

// ===== design/ufc_out_if.sv =====
interface ufc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        is_terminator;
    logic        last;
    logic [15:0] total_length;

    modport source (output valid, output out_byte, output is_terminator, output last,
                    output total_length, input ready);
    modport sink   (input valid, input out_byte, input is_terminator, input last,
                    input total_length, output ready);
endinterface

// ===== design/ufc_front.sv =====
module ufc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [15:0]     cfg_wr_data,
    ufc_in_if.sink          in_ch,
    input  logic            q_full,
    output logic            q_push,
    output ufc_pkg::job_t   q_job
);

    logic [15:0] capacity_reg;
    logic [9:0]  held_high_reg, held_high_next;
    logic        held_valid_reg, held_valid_next;
    logic [15:0] bytes_written_reg, bytes_written_next;
    logic        halted_reg, halted_next;

    logic        accept;
    logic [15:0] u;
    logic        fin;
    logic        is_high, is_low, consumed;
    logic        valid_a, valid_b;
    logic [20:0] cp_a, cp_b;
    ufc_pkg::enc_t enc_a, enc_b;
    logic [16:0] sum_a, base_b, sum_b;
    logic        a_ok, b_ok, halted_a, halted_b;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;
    assign u           = in_ch.code_unit;
    assign fin         = in_ch.last_unit;

    always_comb
    begin
        is_high  = (u >= ufc_pkg::HIGH_SURR_MIN) && (u <= ufc_pkg::HIGH_SURR_MAX);
        is_low   = (u >= ufc_pkg::LOW_SURR_MIN) && (u <= ufc_pkg::LOW_SURR_MAX);
        consumed = held_valid_reg && is_low;

        // Held high surrogate resolves first: either a pair or a replacement.
        valid_a = held_valid_reg;
        cp_a    = is_low ? (ufc_pkg::SUPP_BASE + {1'b0, held_high_reg, u[9:0]})
                         : ufc_pkg::REPL_CP;

        valid_b = !consumed && !(is_high && !fin);
        if (is_high || is_low)
            cp_b = ufc_pkg::REPL_CP;
        else
            cp_b = {5'd0, u};

        enc_a = ufc_pkg::encode_cp(cp_a);
        enc_b = ufc_pkg::encode_cp(cp_b);

        sum_a    = {1'b0, bytes_written_reg} + {14'd0, enc_a.n};
        a_ok     = valid_a && !halted_reg && (sum_a < {1'b0, capacity_reg});
        halted_a = halted_reg || (valid_a && !a_ok);
        base_b   = a_ok ? sum_a : {1'b0, bytes_written_reg};
        sum_b    = base_b + {14'd0, enc_b.n};
        b_ok     = valid_b && !halted_a && (sum_b < {1'b0, capacity_reg});
        halted_b = halted_a || (valid_b && !b_ok);

        q_job.a_bytes   = enc_a.bytes;
        q_job.a_n       = a_ok ? enc_a.n : 3'd0;
        q_job.b_bytes   = enc_b.bytes;
        q_job.b_n       = b_ok ? enc_b.n : 3'd0;
        q_job.term      = fin;
        q_job.total_len = b_ok ? sum_b[15:0] : base_b[15:0];

        // A unit that is only held produces nothing downstream.
        q_push = accept && (a_ok || b_ok || fin);

        held_high_next     = held_high_reg;
        held_valid_next    = held_valid_reg;
        bytes_written_next = bytes_written_reg;
        halted_next        = halted_reg;
        if (accept)
        begin
            if (fin)
            begin
                held_high_next     = '0;
                held_valid_next    = 1'b0;
                bytes_written_next = '0;
                halted_next        = 1'b0;
            end
            else
            begin
                held_valid_next    = !consumed && is_high;
                if (!consumed && is_high)
                    held_high_next = u[9:0];
                bytes_written_next = q_job.total_len;
                halted_next        = halted_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg      <= ufc_pkg::CAPACITY_RST;
            held_high_reg     <= '0;
            held_valid_reg    <= 1'b0;
            bytes_written_reg <= '0;
            halted_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                capacity_reg <= cfg_wr_data;
            held_high_reg     <= held_high_next;
            held_valid_reg    <= held_valid_next;
            bytes_written_reg <= bytes_written_next;
            halted_reg        <= halted_next;
        end
    end

endmodule

// ===== design/ufc_queue.sv =====
module ufc_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ufc_pkg::job_t   push_job,
    input  logic            pop,
    output ufc_pkg::job_t   head_job,
    output logic            empty,
    output logic            full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    ufc_pkg::job_t    slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign head_job = slots_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== design/ufc_back.sv =====
module ufc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  ufc_pkg::job_t   head_job,
    input  logic            q_empty,
    output logic            q_pop,
    ufc_out_if.source       out_ch
);

    logic [3:0]  idx_reg, idx_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_term_reg;
    logic        out_last_reg;
    logic [15:0] out_len_reg;

    logic [3:0]  n_a, n_ab, n_tot, off_b;
    logic        advance;
    logic        item_last;
    logic        item_term;
    logic [7:0]  item_byte;
    logic [15:0] item_len;

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_byte      = out_byte_reg;
    assign out_ch.is_terminator = out_term_reg;
    assign out_ch.last          = out_last_reg;
    assign out_ch.total_length  = out_len_reg;

    // Load the output register from the queue head whenever it is empty or being drained.
    assign advance = !q_empty && (!out_valid_reg || out_ch.ready);
    assign q_pop   = advance && item_last;

    always_comb
    begin
        n_a   = {1'b0, head_job.a_n};
        n_ab  = n_a + {1'b0, head_job.b_n};
        n_tot = n_ab + {3'd0, head_job.term};
        off_b = idx_reg - n_a;
        item_last = (idx_reg == n_tot - 4'd1);
        item_term = 1'b0;
        item_len  = '0;
        if (idx_reg < n_a)
            item_byte = head_job.a_bytes[idx_reg[1:0]];
        else if (idx_reg < n_ab)
            item_byte = head_job.b_bytes[off_b[1:0]];
        else
        begin
            item_byte = '0;
            item_term = 1'b1;
            item_len  = head_job.total_len;
        end
        idx_next = idx_reg;
        if (advance)
            idx_next = item_last ? 4'd0 : idx_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= item_byte;
            out_term_reg <= item_term;
            out_last_reg <= item_last;
            out_len_reg  <= item_len;
        end
    end

endmodule

// ===== design/utf16_to_utf8_converter.sv =====
// UTF-16 to UTF-8 converter.
// in_ch takes one UTF-16 code unit per transaction, with last_unit set on the
// final unit of a string. out_ch gives one UTF-8 byte per transaction; the
// last unit of a string also closes it with a terminator transaction that
// carries total_length. last marks the final output caused by one input unit.
// cfg_wr_en/cfg_wr_data write the destination capacity; write only while idle.
// With the queue and the output register empty, an accepted unit is written
// into the job queue, from which its first byte is loaded into the output register.
// The input side takes a unit every cycle while the job queue has room; the
// output side emits one byte per cycle while the receiver is ready, so a unit
// occupies the output for as many transactions as it yields (1 to 3 bytes for
// BMP text, up to 7 at a string end). A held high surrogate alone yields nothing.
// Reset clears the queue, the surrogate hold and the byte count, and sets the
// capacity to 256. When the receiver stalls, the output register holds its
// transaction, the queue fills, and then in_ch ready drops.
`include "utf16_to_utf8_converter_defines.svh"

module utf16_to_utf8_converter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    ufc_in_if.sink      in_ch,
    ufc_out_if.source   out_ch
);

    ufc_pkg::job_t push_job, head_job;
    logic          q_push, q_pop, q_empty, q_full;

    ufc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    ufc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    ufc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .out_ch   (out_ch)
    );

    `UFC_ASSERT_NOW(a_no_push_when_full, clk, rst_n, q_push, !q_full, "push into full queue")
    `UFC_ASSERT_NOW(a_term_is_last, clk, rst_n, out_ch.valid && out_ch.is_terminator, out_ch.last, "terminator not last")
    `UFC_ASSERT_NOW(a_byte_len_zero, clk, rst_n, out_ch.valid && !out_ch.is_terminator, out_ch.total_length == 16'd0, "length on byte item")
    `UFC_ASSERT_NEXT(a_pop_loads_out, clk, rst_n, q_pop, out_ch.valid && out_ch.last, "popped job did not end on last")

endmodule
